### src/tde_pkg.sv
// Shared types, constants and control codes of the token dictionary name expander.
package tde_pkg;

  // Token byte store and dictionary index sizes.
  localparam int TOKEN_STORE_BYTES = 4096;
  localparam int STORE_AW          = $clog2(TOKEN_STORE_BYTES);
  localparam int INDEX_DEPTH       = 256;
  localparam int INDEX_AW          = $clog2(INDEX_DEPTH);

  // Longest token, counting the bytes walked through in the store.
  localparam int MAX_TOKEN_CHARS = 32;
  localparam int CNT_W           = $clog2(MAX_TOKEN_CHARS + 1);

  // Field widths.
  localparam int CMD_W     = 2;
  localparam int ADDR_W    = 12;
  localparam int VALUE_W   = 12;
  localparam int CHAR_W    = 8;
  localparam int PTR_W     = 12;
  localparam int LEN_W     = 8;
  localparam int MAX_LEN_W = 10;

  localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = MAX_LEN_W'(128);

  // Input command codes.
  localparam logic [CMD_W-1:0] CMD_LOAD_TOKEN = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_INDEX = 2'd1;
  localparam logic [CMD_W-1:0] CMD_START      = 2'd2;
  localparam logic [CMD_W-1:0] CMD_COMPRESSED = 2'd3;

  // One input beat.
  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [ADDR_W-1:0]  address;
    logic [VALUE_W-1:0] value;
  } in_item_t;

  // One result beat.
  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_token;   // write a token byte
    logic load_index;   // write an index entry
    logic start;        // open a new symbol
    logic consume;      // take one compressed byte and read its index entry
    logic token_begin;  // load the token pointer and read its first byte
    logic skip;         // drop the first character of the symbol
    logic emit;         // send the current character
    logic term;         // send the terminator and close the symbol
    logic finish;       // close the symbol without a terminator
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic len_zero;      // start beat carries zero length
    logic bytes_zero;    // no compressed bytes left
    logic finished;      // symbol closed
    logic first_skipped; // first character already dropped
    logic char_zero;     // current token byte is the token end
    logic count_done;    // token length limit reached
    logic room_le1;      // room for the terminator at most
    logic room_zero;     // no room at all
    logic out_free;      // result register can take a beat
  } dp_status_t;

endpackage

### src/token_dictionary_name_expander.sv
// Top level of the token dictionary name expander.
//
// Usage: the item channel (item_valid, item_stall, item) carries load beats for the
// token store and the 256-entry index, start beats with a symbol length, and
// compressed bytes. The result channel (result_valid, result_stall, result) returns
// expanded characters; a zero character with last set ends each symbol unless the
// maximum name length is zero. The cfg channel (cfg_valid, cfg_ready, cfg_data)
// writes the maximum name length; it is always ready. The user must write it only while
// the block is idle; the block itself does not enforce this. A compressed byte is
// expanded in steps: the index lookup, the store address setup, then the token bytes
// one at a time through the single token store read port, up to and including the
// closing zero, and a terminator at the end of the symbol. The first character of
// each symbol is dropped. One beat is worked on at a time; item_stall is high while
// a byte is expanded or a terminator is pending. When the receiver stalls, the result
// register holds its beat and the expansion waits. Synchronous reset clears the
// symbol state, empties the result register and sets the maximum length to 128; the
// stores keep their contents.
module token_dictionary_name_expander (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  tde_pkg::in_item_t             item,
  output logic                          result_valid,
  input  logic                          result_stall,
  output tde_pkg::out_item_t            result,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tde_pkg::MAX_LEN_W-1:0] cfg_data
);

  tde_pkg::ctrl_cmd_t  cmd;
  tde_pkg::dp_status_t status;

  assign cfg_ready = 1'b1;

  // Sequencer.
  tde_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .command    (item.command),
    .item_stall (item_stall),
    .status     (status),
    .cmd        (cmd)
  );

  // Memories, symbol state and result register.
  tde_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cfg_valid    (cfg_valid),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

### src/tde_ctrl.sv
// Controller state machine of the token dictionary name expander.
module tde_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  input  logic [tde_pkg::CMD_W-1:0]   command,
  output logic                        item_stall,
  input  tde_pkg::dp_status_t         status,
  output tde_pkg::ctrl_cmd_t          cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_IDX  = 2'd1;
  localparam logic [1:0] ST_CHR  = 2'd2;
  localparam logic [1:0] ST_TERM = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Items are taken only while no symbol work is in flight.
  assign item_stall = (state != ST_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (item_valid) begin
          case (command)
            tde_pkg::CMD_LOAD_TOKEN: begin
              cmd.load_token = 1'b1;
            end
            tde_pkg::CMD_LOAD_INDEX: begin
              cmd.load_index = 1'b1;
            end
            tde_pkg::CMD_START: begin
              cmd.start = 1'b1;
              if (status.len_zero) begin
                state_next = ST_TERM;
              end
            end
            tde_pkg::CMD_COMPRESSED: begin
              if (!status.bytes_zero) begin
                cmd.consume = 1'b1;
                if (!status.finished) begin
                  state_next = ST_IDX;
                end
              end
            end
            default: begin
              state_next = ST_IDLE;
            end
          endcase
        end
      end
      ST_IDX: begin
        cmd.token_begin = 1'b1;
        state_next      = ST_CHR;
      end
      ST_CHR: begin
        // The length limit is checked before the byte itself.
        if (status.count_done || status.char_zero) begin
          state_next = status.bytes_zero ? ST_TERM : ST_IDLE;
        end else if (!status.first_skipped) begin
          cmd.skip = 1'b1;
        end else if (status.room_le1) begin
          state_next = ST_TERM;
        end else if (status.out_free) begin
          cmd.emit = 1'b1;
        end
      end
      ST_TERM: begin
        if (status.room_zero) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end else if (status.out_free) begin
          cmd.term   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### src/tde_dp.sv
// Datapath of the token dictionary name expander: memories, symbol state and result register.
module tde_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  tde_pkg::in_item_t                item,
  input  logic                             cfg_valid,
  input  logic [tde_pkg::MAX_LEN_W-1:0]    cfg_data,
  input  tde_pkg::ctrl_cmd_t               cmd,
  output tde_pkg::dp_status_t              status,
  output logic                             result_valid,
  input  logic                             result_stall,
  output tde_pkg::out_item_t               result
);

  logic [tde_pkg::CHAR_W-1:0] token_store [tde_pkg::TOKEN_STORE_BYTES];
  logic [tde_pkg::PTR_W-1:0]  index_mem   [tde_pkg::INDEX_DEPTH];

  logic [tde_pkg::CHAR_W-1:0]    store_rdata;
  logic [tde_pkg::PTR_W-1:0]     index_rdata;
  logic [tde_pkg::STORE_AW-1:0]  tok_addr;
  logic [tde_pkg::STORE_AW-1:0]  rd_addr;
  logic                          rd_en;
  logic [tde_pkg::CNT_W-1:0]     count;
  logic [tde_pkg::LEN_W-1:0]     bytes_remaining;
  logic                          first_skipped;
  logic [tde_pkg::MAX_LEN_W-1:0] room_left;
  logic                          symbol_finished;
  logic [tde_pkg::MAX_LEN_W-1:0] max_name_length;
  logic                          advance;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_name_length <= tde_pkg::MAX_LEN_RESET;
    end else if (cfg_valid) begin
      max_name_length <= cfg_data;
    end
  end

  // Token store: loaded by input beats, read one byte a cycle during an unstalled token walk.
  assign advance = cmd.skip | cmd.emit;
  assign rd_en   = cmd.token_begin | advance;
  assign rd_addr = cmd.token_begin ? tde_pkg::STORE_AW'(index_rdata)
                                   : tok_addr + tde_pkg::STORE_AW'(1);

  always_ff @(posedge clk) begin
    if (cmd.load_token) begin
      token_store[tde_pkg::STORE_AW'(item.address)] <= item.value[tde_pkg::CHAR_W-1:0];
    end
    if (rd_en) begin
      store_rdata <= token_store[rd_addr];
    end
  end

  // Dictionary index: addresses at or beyond the index depth are not written.
  always_ff @(posedge clk) begin
    if (cmd.load_index && (item.address < tde_pkg::ADDR_W'(tde_pkg::INDEX_DEPTH))) begin
      index_mem[item.address[tde_pkg::INDEX_AW-1:0]] <= item.value;
    end
    if (cmd.consume) begin
      index_rdata <= index_mem[item.value[tde_pkg::INDEX_AW-1:0]];
    end
  end

  // Token walk address and length counter.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      tok_addr <= rd_addr;
    end
    if (cmd.token_begin) begin
      count <= '0;
    end else if (advance) begin
      count <= count + tde_pkg::CNT_W'(1);
    end
  end

  // Symbol state.
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_remaining <= '0;
      first_skipped   <= 1'b0;
      room_left       <= '0;
      symbol_finished <= 1'b1;
    end else begin
      if (cmd.start) begin
        bytes_remaining <= item.value[tde_pkg::LEN_W-1:0];
        first_skipped   <= 1'b0;
        room_left       <= max_name_length;
        symbol_finished <= 1'b0;
      end
      if (cmd.consume) begin
        bytes_remaining <= bytes_remaining - tde_pkg::LEN_W'(1);
      end
      if (cmd.skip) begin
        first_skipped <= 1'b1;
      end
      if (cmd.emit) begin
        room_left <= room_left - tde_pkg::MAX_LEN_W'(1);
      end
      if (cmd.term || cmd.finish) begin
        symbol_finished <= 1'b1;
      end
    end
  end

  // Result register: holds its beat while the receiver stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit || cmd.term) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result.character <= store_rdata;
      result.last      <= 1'b0;
    end else if (cmd.term) begin
      result.character <= '0;
      result.last      <= 1'b1;
    end
  end

  // Status toward the controller.
  always_comb begin
    status.len_zero      = (item.value[tde_pkg::LEN_W-1:0] == '0);
    status.bytes_zero    = (bytes_remaining == '0);
    status.finished      = symbol_finished;
    status.first_skipped = first_skipped;
    status.char_zero     = (store_rdata == '0);
    status.count_done    = (count == tde_pkg::CNT_W'(tde_pkg::MAX_TOKEN_CHARS));
    status.room_le1      = (room_left <= tde_pkg::MAX_LEN_W'(1));
    status.room_zero     = (room_left == '0);
    status.out_free      = !result_valid || !result_stall;
  end

endmodule
